// ===== hw/rtl/cfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types, constants and the crc-8 byte update for the frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [BYTE_W-1:0] CRC_POLY        = 8'h07;
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hA5;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h5A;
  localparam logic [POS_W-1:0]  SYNC_CHECK_POS  = 9'd4;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 8'd1;

  typedef enum logic [1:0] {
    ST_HELD = 2'd0,
    ST_GOOD = 2'd1,
    ST_BAD  = 2'd2,
    ST_SYNC = 2'd3
  } cfr_status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [POS_W-1:0]  byte_index;
    cfr_status_t       status;
    logic [BYTE_W-1:0] frame_command;
    logic [BYTE_W-1:0] payload_length;
  } cfr_result_t;

  // msb-first crc-8, no reflection, no final xor
  function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/cfr_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_in_reg
// Input register: captures one received byte and holds it until the
// deframer moves it on to the result register.
// ----------------------------------------------------------------------------
module cfr_in_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [cfr_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                       in_stall,
  input  logic                       advance,
  output logic                       byte_valid_r,
  output logic [cfr_pkg::BYTE_W-1:0] byte_r
);

  logic                       byte_valid_nxt;
  logic [cfr_pkg::BYTE_W-1:0] byte_nxt;
  logic                       load;

  // full and not draining this cycle
  assign in_stall = byte_valid_r & ~advance;
  assign load     = in_valid & ~in_stall;

  always_comb begin
    byte_valid_nxt = load | (byte_valid_r & ~advance);
    byte_nxt       = load ? in_rx_byte : byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else begin
      byte_valid_r <= byte_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

// ===== hw/rtl/cfr_deframe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_deframe
// Frame tracking state, sync registers and crc, with the per-byte result
// worked out in one pass from the current state.
// ----------------------------------------------------------------------------
module cfr_deframe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [cfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cfr_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic                          advance,
  input  logic [cfr_pkg::BYTE_W-1:0]    rx_byte,
  output cfr_pkg::cfr_result_t          result
);

  logic [cfr_pkg::BYTE_W-1:0] sync_first_r,  sync_first_nxt;
  logic [cfr_pkg::BYTE_W-1:0] sync_second_r, sync_second_nxt;
  logic [cfr_pkg::POS_W-1:0]  pos_r,         pos_nxt;
  logic                       first_match_r, first_match_nxt;
  logic                       second_match_r, second_match_nxt;
  logic [cfr_pkg::BYTE_W-1:0] cmd_r,         cmd_nxt;
  logic [cfr_pkg::BYTE_W-1:0] len_r,         len_nxt;
  logic [cfr_pkg::BYTE_W-1:0] crc_r,         crc_nxt;
  logic [cfr_pkg::BYTE_W-1:0] crc_fed;
  logic [cfr_pkg::POS_W-1:0]  end_pos;

  always_comb begin
    sync_first_nxt  = sync_first_r;
    sync_second_nxt = sync_second_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        cfr_pkg::REG_SYNC_FIRST:  sync_first_nxt  = cfg_wdata;
        cfr_pkg::REG_SYNC_SECOND: sync_second_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  assign crc_fed = cfr_pkg::crc8_feed(crc_r, rx_byte);
  // crc byte sits at sync check position plus payload length
  assign end_pos = cfr_pkg::SYNC_CHECK_POS + {1'b0, len_r};

  always_comb begin
    pos_nxt          = pos_r;
    first_match_nxt  = first_match_r;
    second_match_nxt = second_match_r;
    cmd_nxt          = cmd_r;
    len_nxt          = len_r;
    crc_nxt          = crc_r;

    result.data_byte      = rx_byte;
    result.byte_index     = pos_r;
    result.status         = cfr_pkg::ST_HELD;
    result.frame_command  = '0;
    result.payload_length = '0;

    if (pos_r == 9'd0) begin
      crc_nxt         = '0;
      first_match_nxt = (rx_byte == sync_first_r);
      pos_nxt         = 9'd1;
    end else if (pos_r == 9'd1) begin
      crc_nxt          = '0;
      second_match_nxt = (rx_byte == sync_second_r);
      pos_nxt          = 9'd2;
    end else if (pos_r == 9'd2) begin
      cmd_nxt = rx_byte;
      crc_nxt = crc_fed;
      pos_nxt = 9'd3;
    end else if (pos_r == 9'd3) begin
      len_nxt = rx_byte;
      crc_nxt = crc_fed;
      pos_nxt = cfr_pkg::SYNC_CHECK_POS;
    end else if (pos_r == cfr_pkg::SYNC_CHECK_POS && !(first_match_r && second_match_r)) begin
      // late sync check: drop the whole five-byte head
      result.status = cfr_pkg::ST_SYNC;
      pos_nxt       = '0;
      crc_nxt       = '0;
    end else if (pos_r >= end_pos) begin
      result.status         = (rx_byte == crc_r) ? cfr_pkg::ST_GOOD : cfr_pkg::ST_BAD;
      result.frame_command  = cmd_r;
      result.payload_length = len_r;
      pos_nxt               = '0;
      crc_nxt               = '0;
    end else begin
      crc_nxt = crc_fed;
      pos_nxt = pos_r + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r   <= cfr_pkg::SYNC_FIRST_RST;
      sync_second_r  <= cfr_pkg::SYNC_SECOND_RST;
      pos_r          <= '0;
      first_match_r  <= 1'b0;
      second_match_r <= 1'b0;
      cmd_r          <= '0;
      len_r          <= '0;
      crc_r          <= '0;
    end else begin
      sync_first_r  <= sync_first_nxt;
      sync_second_r <= sync_second_nxt;
      if (advance) begin
        pos_r          <= pos_nxt;
        first_match_r  <= first_match_nxt;
        second_match_r <= second_match_nxt;
        cmd_r          <= cmd_nxt;
        len_r          <= len_nxt;
        crc_r          <= crc_nxt;
      end
    end
  end

endmodule

// ===== hw/rtl/crc8_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_frame_receiver_unit
// Sync/length/crc-8 frame receiver: echoes each byte with its frame index
// and a held / commit / drop status.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel: one received byte per item (in_valid / in_stall).
//   out_* channel: one result item per input item, in order, carrying the
//   byte, its index in the frame, a status and, on frame end, the command
//   and length bytes. the consumer keeps or drops echoed bytes by status.
//   cfg_*: plain write port for the two sync byte registers; write only
//   while no item is in flight.
// Pipeline: an accepted item passes the input register, then the result
//   register, where out_valid shows it. Throughput: one item per cycle while
//   out_stall is low, set by the combinational crc update feeding the frame
//   state registers.
// Reset: rst_n low clears the valid flags of both pipeline registers and the
//   frame state; sync registers return to 0xa5 and 0x5a.
// Stall: with out_stall high the result register holds, the input register
//   fills, then in_stall rises; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module crc8_frame_receiver_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [cfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cfr_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  input  logic [cfr_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cfr_pkg::BYTE_W-1:0]    out_data_byte,
  output logic [cfr_pkg::POS_W-1:0]     out_byte_index,
  output logic [1:0]                    out_status,
  output logic [cfr_pkg::BYTE_W-1:0]    out_frame_command,
  output logic [cfr_pkg::BYTE_W-1:0]    out_payload_length
);

  logic                       byte_valid_r;
  logic [cfr_pkg::BYTE_W-1:0] byte_r;
  logic                       advance;
  cfr_pkg::cfr_result_t       result;
  cfr_pkg::cfr_result_t       out_res_r, out_res_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // item moves on when the result register is empty or being taken
  assign advance = byte_valid_r & (~out_valid_r | ~out_stall);

  cfr_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_rx_byte   (in_rx_byte),
    .in_stall     (in_stall),
    .advance      (advance),
    .byte_valid_r (byte_valid_r),
    .byte_r       (byte_r)
  );

  cfr_deframe u_deframe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .rx_byte   (byte_r),
    .result    (result)
  );

  always_comb begin
    out_valid_nxt = advance | (out_valid_r & out_stall);
    out_res_nxt   = advance ? result : out_res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_data_byte      = out_res_r.data_byte;
  assign out_byte_index     = out_res_r.byte_index;
  assign out_status         = out_res_r.status;
  assign out_frame_command  = out_res_r.frame_command;
  assign out_payload_length = out_res_r.payload_length;

`ifndef SYNTHESIS
  // sync drop is only reported at the sync check position
  a_sync_at_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == cfr_pkg::ST_SYNC |-> out_byte_index == cfr_pkg::SYNC_CHECK_POS)
    else $error("sync drop reported away from sync check position");

  // frame end lands exactly on the crc byte position
  a_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == cfr_pkg::ST_GOOD || out_status == cfr_pkg::ST_BAD)
    |-> out_byte_index == cfr_pkg::SYNC_CHECK_POS + {1'b0, out_payload_length})
    else $error("frame end at wrong byte index");

  // header fields are only shown on frame end
  a_held_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == cfr_pkg::ST_HELD || out_status == cfr_pkg::ST_SYNC)
    |-> out_frame_command == '0 && out_payload_length == '0)
    else $error("header fields leak on non-final item");

  // input side only blocks while the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
`endif

endmodule

// ===== sim/tb_crc8_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc8_frame_receiver_unit
// Streams framed and broken byte sequences into the frame receiver under
// several sync byte settings. Every echoed item is checked against a
// predicted echo, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_crc8_frame_receiver_unit;

  localparam int QUIET_LIMIT = 2000;

  // expected echo per accepted byte, plus a private copy of the frame state
  class frame_echo_board;
    logic [cfr_pkg::BYTE_W-1:0] sync_a, sync_b;
    logic [cfr_pkg::POS_W-1:0]  pos;
    bit                         match_a, match_b;
    logic [cfr_pkg::BYTE_W-1:0] cmd, len, crc;
    cfr_pkg::cfr_result_t       echo_q[$];
    int unsigned                accepted;
    int unsigned                fail_count;

    function new();
      sync_a = cfr_pkg::SYNC_FIRST_RST;
      sync_b = cfr_pkg::SYNC_SECOND_RST;
      pos = '0;
      match_a = 0;
      match_b = 0;
      cmd = '0;
      len = '0;
      crc = '0;
      accepted = 0;
      fail_count = 0;
    endfunction

    static function logic [cfr_pkg::BYTE_W-1:0] crc_next(logic [cfr_pkg::BYTE_W-1:0] acc,
                                                         logic [cfr_pkg::BYTE_W-1:0] b);
      logic [cfr_pkg::BYTE_W-1:0] c;
      c = acc ^ b;
      repeat (8) c = c[cfr_pkg::BYTE_W-1] ? ({c[cfr_pkg::BYTE_W-2:0], 1'b0} ^ cfr_pkg::CRC_POLY)
                                          : {c[cfr_pkg::BYTE_W-2:0], 1'b0};
      return c;
    endfunction

    function void set_reg(logic [cfr_pkg::CFG_IDX_W-1:0] idx,
                          logic [cfr_pkg::BYTE_W-1:0] val);
      if (idx == cfr_pkg::REG_SYNC_FIRST) sync_a = val;
      else if (idx == cfr_pkg::REG_SYNC_SECOND) sync_b = val;
    endfunction

    function void note_byte(logic [cfr_pkg::BYTE_W-1:0] b);
      cfr_pkg::cfr_result_t want;
      int                   p;
      p = int'(pos);
      want.data_byte = b;
      want.byte_index = pos;
      want.status = cfr_pkg::ST_HELD;
      want.frame_command = '0;
      want.payload_length = '0;
      if (p == 0) begin
        crc = '0;
        match_a = (b == sync_a);
        pos = 9'd1;
      end else if (p == 1) begin
        crc = '0;
        match_b = (b == sync_b);
        pos = 9'd2;
      end else if (p == 2) begin
        cmd = b;
        crc = crc_next(crc, b);
        pos = 9'd3;
      end else if (p == 3) begin
        len = b;
        crc = crc_next(crc, b);
        pos = 9'd4;
      end else if (p == int'(cfr_pkg::SYNC_CHECK_POS) && !(match_a && match_b)) begin
        // sync is judged late, all five bytes go
        want.status = cfr_pkg::ST_SYNC;
        pos = '0;
        crc = '0;
      end else if (p >= int'(cfr_pkg::SYNC_CHECK_POS) + int'(len)) begin
        want.status = (b == crc) ? cfr_pkg::ST_GOOD : cfr_pkg::ST_BAD;
        want.frame_command = cmd;
        want.payload_length = len;
        pos = '0;
        crc = '0;
      end else begin
        crc = crc_next(crc, b);
        pos = pos + 1'b1;
      end
      echo_q.push_back(want);
      accepted++;
    endfunction

    function void cmp(string name, logic [cfr_pkg::POS_W-1:0] exp_v,
                      logic [cfr_pkg::POS_W-1:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        fail_count++;
      end
    endfunction

    function void check_echo(logic [cfr_pkg::BYTE_W-1:0] d, logic [cfr_pkg::POS_W-1:0] idx,
                             logic [1:0] st, logic [cfr_pkg::BYTE_W-1:0] c,
                             logic [cfr_pkg::BYTE_W-1:0] l);
      cfr_pkg::cfr_result_t want;
      if (echo_q.size() == 0) begin
        $error("result item with nothing pending: data_byte %0d index %0d", d, idx);
        fail_count++;
        return;
      end
      want = echo_q.pop_front();
      cmp("data_byte", {1'b0, want.data_byte}, {1'b0, d});
      cmp("byte_index", want.byte_index, idx);
      cmp("status", {7'b0, want.status}, {7'b0, st});
      cmp("frame_command", {1'b0, want.frame_command}, {1'b0, c});
      cmp("payload_length", {1'b0, want.payload_length}, {1'b0, l});
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [cfr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cfr_pkg::BYTE_W-1:0]    cfg_wdata;
  logic                          in_valid;
  logic [cfr_pkg::BYTE_W-1:0]    in_rx_byte;
  logic                          in_stall;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [cfr_pkg::BYTE_W-1:0]    out_data_byte;
  logic [cfr_pkg::POS_W-1:0]     out_byte_index;
  logic [1:0]                    out_status;
  logic [cfr_pkg::BYTE_W-1:0]    out_frame_command;
  logic [cfr_pkg::BYTE_W-1:0]    out_payload_length;

  frame_echo_board board;
  int              quiet_cycles = 0;
  int              burst_left = 0;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_span = 0;

  crc8_frame_receiver_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_rx_byte         (in_rx_byte),
    .in_stall           (in_stall),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data_byte      (out_data_byte),
    .out_byte_index     (out_byte_index),
    .out_status         (out_status),
    .out_frame_command  (out_frame_command),
    .out_payload_length (out_payload_length)
  );

  always #4 clk = ~clk;

  // receiver stall pattern: quiet stretches, random stalls, periodic stalls
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_span = $urandom_range(8, 40);
    end
    case (stall_mode)
      STALL_NONE:     out_stall = 1'b0;
      STALL_RANDOM:   out_stall = ($urandom_range(0, 2) == 0);
      default:        out_stall = ((stall_span % 8) < 5);
    endcase
    stall_span--;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_byte(in_rx_byte);
      if (out_valid && !out_stall)
        board.check_echo(out_data_byte, out_byte_index, out_status,
                         out_frame_command, out_payload_length);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [cfr_pkg::BYTE_W-1:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [cfr_pkg::BYTE_W-1:0] rand_flip();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic wait_accept();
    do @(posedge clk); while (in_stall);
  endtask

  task automatic push_byte(input logic [cfr_pkg::BYTE_W-1:0] b);
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_rx_byte = b;
    wait_accept();
  endtask

  // feed filler until the receiver is back at the start of a frame
  task automatic realign();
    bit done;
    done = 0;
    while (!done) begin
      @(negedge clk);
      if (board.pos == 0) begin
        in_valid = 1'b0;
        done = 1;
      end else begin
        in_valid = 1'b1;
        in_rx_byte = rand_byte();
        wait_accept();
      end
    end
  endtask

  task automatic send_body(input bit sync_ok, input logic [cfr_pkg::BYTE_W-1:0] c,
                           input logic [cfr_pkg::BYTE_W-1:0] n, input bit bad);
    logic [cfr_pkg::BYTE_W-1:0] acc, pb;
    int                         i;
    acc = frame_echo_board::crc_next(frame_echo_board::crc_next(8'h00, c), n);
    push_byte(c);
    push_byte(n);
    // on a sync mismatch the byte at index 4 ends the frame
    if (sync_ok) begin
      for (i = 0; i < n; i++) begin
        pb = rand_byte();
        acc = frame_echo_board::crc_next(acc, pb);
        push_byte(pb);
      end
    end
    if (bad) acc = acc ^ rand_flip();
    push_byte(acc);
  endtask

  task automatic send_frame(input logic [cfr_pkg::BYTE_W-1:0] s1,
                            input logic [cfr_pkg::BYTE_W-1:0] s2,
                            input logic [cfr_pkg::BYTE_W-1:0] c,
                            input logic [cfr_pkg::BYTE_W-1:0] n,
                            input bit bad);
    bit ok;
    ok = (s1 == board.sync_a) && (s2 == board.sync_b);
    push_byte(s1);
    push_byte(s2);
    send_body(ok, c, n, bad);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.echo_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cfr_pkg::BYTE_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    board.set_reg(idx, val);
  endtask

  task automatic run_traffic(input int unsigned stop_at);
    logic [cfr_pkg::BYTE_W-1:0] s1, s2, n;
    int                         r;
    while (board.accepted < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        // broken sequence: a few stray bytes, then fill to a frame boundary
        repeat ($urandom_range(1, 6)) push_byte(rand_byte());
        realign();
      end else begin
        s1 = board.sync_a;
        s2 = board.sync_b;
        r = $urandom_range(0, 99);
        if (r < 8) s1 = s1 ^ rand_flip();
        else if (r < 16) s2 = s2 ^ rand_flip();
        else if (r < 19) begin
          s1 = s1 ^ rand_flip();
          s2 = s2 ^ rand_flip();
        end
        r = $urandom_range(0, 99);
        if (r < 70) n = 8'($urandom_range(0, 6));
        else if (r < 98) n = 8'($urandom_range(7, 40));
        else n = 8'($urandom_range(41, 255));
        send_frame(s1, s2, rand_byte(), n, $urandom_range(0, 9) == 0);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    board = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset sync values
    send_frame(cfr_pkg::SYNC_FIRST_RST, cfr_pkg::SYNC_SECOND_RST, 8'h00, 8'h00, 0);
    send_frame(cfr_pkg::SYNC_FIRST_RST, cfr_pkg::SYNC_SECOND_RST, 8'hFF, 8'h01, 0);
    send_frame(cfr_pkg::SYNC_FIRST_RST, cfr_pkg::SYNC_SECOND_RST, 8'h3C, 8'h00, 1);
    // zero length with a bad first sync byte: sync drop wins over crc
    send_frame(cfr_pkg::SYNC_SECOND_RST, cfr_pkg::SYNC_SECOND_RST, 8'h81, 8'h00, 0);
    send_frame(cfr_pkg::SYNC_FIRST_RST, cfr_pkg::SYNC_FIRST_RST, 8'h42, 8'h02, 0);

    drain();
    write_reg(cfr_pkg::REG_SYNC_FIRST, 8'h00);
    write_reg(cfr_pkg::REG_SYNC_SECOND, 8'hFF);
    // longest frame, indexes up to 259
    send_frame(8'h00, 8'hFF, rand_byte(), 8'hFF, 0);
    run_traffic(board.accepted + 70);

    // sync bytes arrive under the old setting, rest of frame under the new
    push_byte(board.sync_a);
    push_byte(board.sync_b);
    drain();
    write_reg(cfr_pkg::REG_SYNC_FIRST, 8'hFF);
    write_reg(cfr_pkg::REG_SYNC_SECOND, 8'h00);
    write_reg(cfr_pkg::REG_SYNC_SECOND + 1'b1, rand_byte());
    write_reg({cfr_pkg::CFG_IDX_W{1'b1}}, rand_byte());
    send_body(1, rand_byte(), 8'h03, 0);
    run_traffic(board.accepted + 50);

    drain();
    write_reg(cfr_pkg::REG_SYNC_FIRST, rand_byte());
    write_reg(cfr_pkg::REG_SYNC_SECOND, rand_byte());
    run_traffic(board.accepted + 50);

    drain();
    write_reg(cfr_pkg::REG_SYNC_FIRST, cfr_pkg::SYNC_FIRST_RST);
    write_reg(cfr_pkg::REG_SYNC_SECOND, cfr_pkg::SYNC_SECOND_RST);
    run_traffic(board.accepted + 50);

    @(negedge clk);
    in_valid = 1'b0;
    while (board.echo_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.fail_count == 0 && board.echo_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== crc8_frame_receiver_unit.f =====
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_in_reg.sv
hw/rtl/cfr_deframe.sv
hw/rtl/crc8_frame_receiver_unit.sv
sim/tb_crc8_frame_receiver_unit.sv
